// ===== src/ppdc_pkg.sv =====
`timescale 1ns / 1ps

package ppdc_pkg;

  // Fixed field widths of the stream items and the register.
  localparam int CountW  = 16;
  localparam int WrapW   = 16;
  localparam int StampW  = 32;
  localparam int RateW   = 27;
  localparam int FreqW   = 37;
  localparam int DutyW   = 14;
  localparam int DutyNumW = StampW + DutyW;

  // Packed widths on the stream ports.
  localparam int InDataW  = 2 * CountW;
  localparam int InUserW  = 2;
  localparam int OutFieldsW = 2 * StampW + FreqW + DutyW;
  localparam int OutDataW = ((OutFieldsW + 7) / 8) * 8;

  // Bit positions inside the input tuser.
  localparam int UserOvfBit = 0;
  localparam int UserCapBit = 1;

  localparam logic [RateW-1:0] RateResetHz = RateW'(1000000);
  localparam logic [9:0]       MilliScale  = 10'd1000;
  localparam logic [13:0]      DutyScale   = 14'd10000;

  // Restoring division: one quotient bit per step.
  localparam int FreqSteps = FreqW;
  localparam int DutySteps = DutyW;
  localparam int StepW     = $clog2(FreqSteps);

  // Job queue between the front and the back end.
  localparam int QueueDepth = 2;
  localparam int QueueAw    = $clog2(QueueDepth);

  typedef struct packed {
    logic [StampW-1:0] period;
    logic [StampW-1:0] high;
  } job_t;

  typedef enum logic [1:0] {
    BkIdle,
    BkMul,
    BkDiv,
    BkDone
  } back_state_e;

endpackage

// ===== src/ppdc_front.sv =====
`timescale 1ns / 1ps

module ppdc_front #(
  parameter int COUNTER_WIDTH = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // fall_count, rise_count
  input  logic [ppdc_pkg::InDataW-1:0] s_axis_tdata_i,
  // overflow_flag, capture_flag
  input  logic [ppdc_pkg::InUserW-1:0] s_axis_tuser_i,
  input  logic                         full_i,
  output logic                         push_o,
  output ppdc_pkg::job_t               job_o
);
  import ppdc_pkg::*;

  localparam int CntBits = (COUNTER_WIDTH < CountW) ? COUNTER_WIDTH : CountW;
  localparam logic [CountW-1:0] CntMask = CountW'((64'd1 << CntBits) - 64'd1);
  localparam logic [32:0] HalfScale = 33'd1 << (COUNTER_WIDTH - 1);

  logic [WrapW-1:0]  wrap_q, wrap_d;
  logic [StampW-1:0] last_fall_q, last_fall_d;

  logic              accept;
  logic              ovf, cap;
  logic [CountW-1:0] fall_m, rise_m;
  logic [WrapW-1:0]  wraps_fall, wraps_rise;
  logic [StampW-1:0] fall_ts, rise_ts, high, period;

  // Wrap count goes above the counter bits; at full width it falls off the top.
  function automatic logic [StampW-1:0] make_stamp(logic [WrapW-1:0] w,
                                                    logic [CountW-1:0] c);
    logic [63:0] hi;
    hi = {48'd0, w} << COUNTER_WIDTH;
    return hi[StampW-1:0] | {{(StampW-CountW){1'b0}}, c};
  endfunction

  assign s_axis_tready_o = !full_i;
  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  assign ovf    = s_axis_tuser_i[UserOvfBit];
  assign cap    = s_axis_tuser_i[UserCapBit];
  assign fall_m = s_axis_tdata_i[CountW-1:0] & CntMask;
  assign rise_m = s_axis_tdata_i[2*CountW-1:CountW] & CntMask;

  always_comb begin
    // An overflow in the same event belongs before the fall only when the
    // fall sits in the lower half of the counter range.
    if (ovf && ({17'd0, fall_m} < HalfScale)) begin
      wraps_fall = wrap_q + WrapW'(1);
    end else begin
      wraps_fall = wrap_q;
    end
    if (rise_m > fall_m) begin
      wraps_rise = wraps_fall - WrapW'(1);
    end else begin
      wraps_rise = wraps_fall;
    end
  end

  assign fall_ts = make_stamp(wraps_fall, fall_m);
  assign rise_ts = make_stamp(wraps_rise, rise_m);
  assign high    = fall_ts - rise_ts;
  assign period  = fall_ts - last_fall_q;

  assign push_o       = accept && cap && (period != '0) && (high < period);
  assign job_o.period = period;
  assign job_o.high   = high;

  always_comb begin
    wrap_d      = wrap_q;
    last_fall_d = last_fall_q;
    if (accept) begin
      if (cap) begin
        last_fall_d = fall_ts;
      end
      if (ovf) begin
        wrap_d = wrap_q + WrapW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wrap_q      <= '0;
      last_fall_q <= '0;
    end else begin
      wrap_q      <= wrap_d;
      last_fall_q <= last_fall_d;
    end
  end

endmodule

// ===== src/ppdc_fifo.sv =====
`timescale 1ns / 1ps

module ppdc_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ppdc_pkg::job_t data_i,
  output logic           full_o,
  output logic           valid_o,
  input  logic           pop_i,
  output ppdc_pkg::job_t data_o
);
  import ppdc_pkg::*;

  job_t               mem_q [QueueDepth];
  logic [QueueAw-1:0] wr_ptr_q, wr_ptr_d;
  logic [QueueAw-1:0] rd_ptr_q, rd_ptr_d;
  logic [QueueAw:0]   count_q, count_d;
  logic               do_push, do_pop;

  assign full_o  = (count_q == (QueueAw+1)'(QueueDepth));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + QueueAw'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + QueueAw'(1) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + (QueueAw+1)'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - (QueueAw+1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ===== src/ppdc_back.sv =====
`timescale 1ns / 1ps

module ppdc_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          job_valid_i,
  input  ppdc_pkg::job_t                job_i,
  output logic                          pop_o,
  input  logic [ppdc_pkg::RateW-1:0]    tick_rate_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // period_ticks, high_ticks, freq_millihertz, duty_hundredths, zero fill
  output logic [ppdc_pkg::OutDataW-1:0] m_axis_tdata_o
);
  import ppdc_pkg::*;

  back_state_e state_q, state_d;

  logic [StampW-1:0] period_q, high_q;
  logic [StepW-1:0]  step_q;
  logic [StampW-1:0] freq_rem_q;
  logic [FreqW-1:0]  freq_num_q;
  logic [StampW-1:0] duty_rem_q;
  logic [DutyW-1:0]  duty_num_q;

  logic              out_valid_q, out_valid_d;
  logic [StampW-1:0] out_period_q, out_high_q;
  logic [FreqW-1:0]  out_freq_q;
  logic [DutyW-1:0]  out_duty_q;

  logic              take_job, load_mul, run_div, load_out, last_step, slot_free;
  logic [FreqW-1:0]    freq_prod;
  logic [DutyNumW-1:0] duty_prod;
  logic [StampW:0]     freq_shift, freq_diff, duty_shift, duty_diff;
  logic                freq_ge, duty_ge;

  assign last_step = (step_q == StepW'(FreqSteps - 1));
  assign slot_free = !out_valid_q || m_axis_tready_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BkIdle: if (job_valid_i) state_d = BkMul;
      BkMul:  state_d = BkDiv;
      BkDiv:  if (last_step) state_d = BkDone;
      BkDone: if (slot_free) state_d = BkIdle;
      default: state_d = BkIdle;
    endcase
  end

  // State outputs.
  always_comb begin
    take_job = 1'b0;
    load_mul = 1'b0;
    run_div  = 1'b0;
    load_out = 1'b0;
    unique case (state_q)
      BkIdle: take_job = job_valid_i;
      BkMul:  load_mul = 1'b1;
      BkDiv:  run_div  = 1'b1;
      BkDone: load_out = slot_free;
      default: ;
    endcase
  end

  assign pop_o = take_job;

  assign freq_prod = FreqW'(tick_rate_i) * FreqW'(MilliScale);
  assign duty_prod = DutyNumW'(high_q) * DutyNumW'(DutyScale);

  // One restoring step per lane and cycle; the remainder never reaches the period.
  assign freq_shift = {freq_rem_q, freq_num_q[FreqW-1]};
  assign freq_diff  = freq_shift - {1'b0, period_q};
  assign freq_ge    = (freq_shift >= {1'b0, period_q});
  assign duty_shift = {duty_rem_q, duty_num_q[DutyW-1]};
  assign duty_diff  = duty_shift - {1'b0, period_q};
  assign duty_ge    = (duty_shift >= {1'b0, period_q});

  always_ff @(posedge clk_i) begin
    if (take_job) begin
      period_q <= job_i.period;
      high_q   <= job_i.high;
    end
    if (load_mul) begin
      freq_rem_q <= '0;
      freq_num_q <= freq_prod;
      // The duty quotient fits in its own width because high is below period,
      // so the upper part of the product already starts below the divisor.
      duty_rem_q <= duty_prod[DutyNumW-1:DutyW];
      duty_num_q <= duty_prod[DutyW-1:0];
      step_q     <= '0;
    end
    if (run_div) begin
      freq_rem_q <= freq_ge ? freq_diff[StampW-1:0] : freq_shift[StampW-1:0];
      freq_num_q <= {freq_num_q[FreqW-2:0], freq_ge};
      if (step_q < StepW'(DutySteps)) begin
        duty_rem_q <= duty_ge ? duty_diff[StampW-1:0] : duty_shift[StampW-1:0];
        duty_num_q <= {duty_num_q[DutyW-2:0], duty_ge};
      end
      step_q <= step_q + StepW'(1);
    end
    if (load_out) begin
      out_period_q <= period_q;
      out_high_q   <= high_q;
      out_freq_q   <= freq_num_q;
      out_duty_q   <= duty_num_q;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BkIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OutDataW - OutFieldsW){1'b0}},
                            out_duty_q, out_freq_q, out_high_q, out_period_q};

  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BkDiv) |-> (step_q <= StepW'(FreqSteps - 1)))
    else $error("division step counter ran past the last quotient bit");

  a_freq_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BkDiv) |-> (freq_rem_q < period_q))
    else $error("frequency remainder not below the period");

  a_duty_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BkDiv) |-> (duty_rem_q < period_q))
    else $error("duty remainder not below the period");

  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ((out_high_q < out_period_q) &&
                            (out_duty_q < DutyScale)))
    else $error("result beat with high time or duty out of range");

endmodule

// ===== src/pwm_period_duty_capture.sv =====
`timescale 1ns / 1ps

// PWM period and duty measurement from input-capture events. Each input beat
// reports whether the free-running capture counter wrapped (tuser bit 0) and
// whether a falling edge was captured (tuser bit 1), with the falling and the
// latest rising capture counts in tdata. The front end keeps the wrap count
// and the previous fall timestamp, extends the counts to 32-bit timestamps,
// and works out high time and period in the cycle the beat is accepted; only
// a plausible measurement (non-zero period, high time below period) is queued.
// The back end turns a queued job into frequency in millihertz and duty in
// hundredths of a percent with two restoring dividers that run side by side,
// one quotient bit per cycle. From leaving the queue to its result beat, a
// measurement goes through taking the job, the two multiplications, the
// frequency division (the longer quotient) and the load of the output
// register, which waits until the output slot is free. Events without a
// capture, and invalid captures, are consumed by the front end and give no
// result beat. A two-entry queue sits between the two halves, so input beats
// keep being taken while a result waits on the output, until the queue fills.
// The tick rate register resets to 1 MHz and should only be written while no
// measurement is in flight.

module pwm_period_duty_capture #(
  parameter int COUNTER_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Tick rate register write.
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ppdc_pkg::RateW-1:0]    cfg_data_i,
  // Capture events.
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // [15:0] fall_count, [31:16] rise_count
  input  logic [ppdc_pkg::InDataW-1:0]  s_axis_tdata_i,
  // [0] overflow_flag, [1] capture_flag
  input  logic [ppdc_pkg::InUserW-1:0]  s_axis_tuser_i,
  // Measurements.
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [31:0] period_ticks, [63:32] high_ticks, [100:64] freq_millihertz,
  // [114:101] duty_hundredths, [119:115] zero
  output logic [ppdc_pkg::OutDataW-1:0] m_axis_tdata_o
);
  import ppdc_pkg::*;

  logic [RateW-1:0] tick_rate_q, tick_rate_d;

  logic push, full, job_valid, pop;
  job_t job_in, job_out;

  // The register is always ready to take a write beat.
  assign cfg_ready_o = 1'b1;
  assign tick_rate_d = (cfg_valid_i && cfg_ready_o) ? cfg_data_i : tick_rate_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_rate_q <= RateResetHz;
    end else begin
      tick_rate_q <= tick_rate_d;
    end
  end

  // Timestamp extension and validity check, one event per cycle if not full.
  ppdc_front #(
    .COUNTER_WIDTH(COUNTER_WIDTH)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .full_i         (full),
    .push_o         (push),
    .job_o          (job_in)
  );

  // Short job queue decoupling event intake from the dividers.
  ppdc_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (job_in),
    .full_o (full),
    .valid_o(job_valid),
    .pop_i  (pop),
    .data_o (job_out)
  );

  // Frequency and duty division and the output register.
  ppdc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_valid_i    (job_valid),
    .job_i          (job_out),
    .pop_o          (pop),
    .tick_rate_i    (tick_rate_q),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

endmodule
